/* sv/mct_pkg.sv */
// shared types, codes and constants of the multitouch contact tracker
package mct_pkg;

  localparam int MAX_SLOTS_DEF = 16;
  localparam int CNT_W         = 5;
  localparam int ID_W          = 4;
  localparam int RAW_W         = 32;
  localparam int NORM_W        = 17;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 16;

  localparam logic [4:0] EVT_SYN = 5'd0;
  localparam logic [4:0] EVT_KEY = 5'd1;
  localparam logic [4:0] EVT_ABS = 5'd3;

  localparam logic [9:0] C_ABS_X      = 10'd0;
  localparam logic [9:0] C_ABS_Y      = 10'd1;
  localparam logic [9:0] C_MT_SLOT    = 10'd47;
  localparam logic [9:0] C_MT_X       = 10'd53;
  localparam logic [9:0] C_MT_Y       = 10'd54;
  localparam logic [9:0] C_MT_TRACK   = 10'd57;
  localparam logic [9:0] C_BTN_TOUCH  = 10'd330;
  localparam logic [9:0] C_SYN_REPORT = 10'd0;

  localparam logic [CFG_IDX_W-1:0] REG_SLOT_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACTIVE    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_MIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_X_MAX     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MIN     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_Y_MAX     = 3'd5;

  localparam logic [NORM_W-1:0] NORM_ONE = 17'd65536;

  typedef enum logic [1:0] {
    PH_DOWN   = 2'd0,
    PH_MOVE   = 2'd1,
    PH_UP     = 2'd2,
    PH_CANCEL = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WALK,
    ST_NORM,
    ST_OUT
  } state_t;

  // handshake between control and the bit-serial normalizer
  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } norm_ctl_t;

endpackage

/* sv/mct_norm.sv */
// bit-serial normalizer: clamp, then restoring division one quotient bit per cycle
module mct_norm
  import mct_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [RAW_W-1:0]  raw,
  input  logic signed [15:0]       lo,
  input  logic signed [15:0]       hi,
  output norm_ctl_t                ctl,
  output logic [NORM_W-1:0]        result
);

  localparam int QB = 16;

  logic signed [RAW_W:0] span_w, d_w;
  logic [4:0]            cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt, done_r, done_nxt;
  logic [16:0]           span_r, span_nxt;
  logic [17:0]           rem_r, rem_nxt;
  logic [15:0]           num_r, num_nxt;
  logic [NORM_W-1:0]     q_r, q_nxt;
  logic [17:0]           trial;

  assign span_w = (RAW_W+1)'(hi) - (RAW_W+1)'(lo);
  assign d_w    = {raw[RAW_W-1], raw} - (RAW_W+1)'(lo);
  assign trial  = {rem_r[16:0], num_r[15]};

  always_comb begin
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    span_nxt = span_r;
    rem_nxt  = rem_r;
    num_nxt  = num_r;
    q_nxt    = q_r;
    if (start) begin
      span_nxt = span_w[16:0];
      priority if (span_w <= 0 || d_w <= 0) begin
        q_nxt = '0; done_nxt = 1'b1;
      end else if (d_w >= span_w) begin
        q_nxt = NORM_ONE; done_nxt = 1'b1;
      end else begin
        // numerator d*65536 + span/2: clear the remainder, seed the shift bits with d; span/2 follows
        rem_nxt  = '0;
        num_nxt  = d_w[15:0];
        q_nxt    = '0;
        cnt_nxt  = 5'd0;
        busy_nxt = 1'b1;
      end
    end else if (busy_r) begin
      // quotient of (d<<16 + span>>1) / span; first 16 steps feed d, next 16 feed span/2
      if (trial >= {1'b0, span_r}) begin
        rem_nxt = trial - {1'b0, span_r};
        q_nxt   = {q_r[NORM_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt   = {q_r[NORM_W-2:0], 1'b0};
      end
      num_nxt = (cnt_r == 5'd15) ? span_r[16:1] : {num_r[14:0], 1'b0};
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(2*QB-1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    span_r <= span_nxt;
    rem_r  <= rem_nxt;
    num_r  <= num_nxt;
    q_r    <= q_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign result    = q_r;

`ifndef SYNTHESIS
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> !start) else $error("normalizer restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r && !start |=> !done_r) else $error("done held");
  a_result_range: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> q_r <= NORM_ONE) else $error("normalized value above one");
`endif

endmodule

/* sv/multitouch_contact_tracker.sv */
// top level: event decode, slot state, sync walk, serial normalize, output register
//   channel | direction | fields
//   in_     | in        | req_type ev_type ev_code ev_value
//   out_    | out       | phase contact_id raw_x raw_y norm_x norm_y last_of_run
//   cfg_    | in        | we idx data (write only)
// non-sync events are absorbed in idle; a sync or stop walks one slot per cycle over slots
// without a result, and a slot with a result goes through walk, two serial divides (x then y,
// each 32 quotient steps plus done) and output load; a clamped axis skips its quotient steps.
// up to the active slot count (clamped to 1..MAX_SLOTS) results per item.
// reset is synchronous; slot state clears at once, no clearing pass.
// a stalled out_ready holds the walk; no new item is taken until the last result leaves.
module multitouch_contact_tracker
  import mct_pkg::*;
#(
  parameter int MAX_SLOTS = MAX_SLOTS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_req_type,
  input  logic [4:0]              in_ev_type,
  input  logic [9:0]              in_ev_code,
  input  logic signed [RAW_W-1:0] in_ev_value,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [1:0]              out_phase,
  output logic [ID_W-1:0]         out_contact_id,
  output logic signed [RAW_W-1:0] out_raw_x,
  output logic signed [RAW_W-1:0] out_raw_y,
  output logic [NORM_W-1:0]       out_norm_x,
  output logic [NORM_W-1:0]       out_norm_y,
  output logic                    out_last_of_run,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_idx,
  input  logic [CFG_DATA_W-1:0]   cfg_data
);

  localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;

  logic                      slot_mode_r;
  logic [CNT_W-1:0]          active_r;
  logic signed [15:0]        x_min_r, x_max_r, y_min_r, y_max_r;

  logic [MAX_SLOTS-1:0]      present_r, present_nxt, down_r, down_nxt, moved_r, moved_nxt;
  logic signed [RAW_W-1:0]   cx_r [MAX_SLOTS];
  logic signed [RAW_W-1:0]   cy_r [MAX_SLOTS];
  logic [SW-1:0]             sel_r, sel_nxt;
  logic                      single_moved_r, single_moved_nxt, button_r, button_nxt;

  state_t                    state_r, state_nxt;
  logic                      stop_r, stop_nxt;
  logic [SW:0]               idx_r, idx_nxt;
  logic [SW:0]               n_slots;
  logic                      axis_y_r, axis_y_nxt;
  logic [1:0]                ph_r, ph_nxt;
  logic [SW-1:0]             eslot_r, eslot_nxt;
  logic [NORM_W-1:0]         nx_r, ny_r;

  logic [1:0]                o_phase_r;
  logic [ID_W-1:0]           o_id_r;
  logic signed [RAW_W-1:0]   o_rx_r, o_ry_r;
  logic [NORM_W-1:0]         o_nx_r, o_ny_r;
  logic                      o_last_r, o_valid_r, o_valid_nxt;

  logic                      in_fire, norm_start, hit, is_last, load_out;
  logic [1:0]                hit_ph;
  logic [SW-1:0]             widx;
  norm_ctl_t                 nctl;
  logic [NORM_W-1:0]         nres;
  logic signed [RAW_W-1:0]   n_raw;
  logic signed [15:0]        n_lo, n_hi;

  // clamp active slot count to 1..MAX_SLOTS
  always_comb begin
    if (active_r == '0) n_slots = (SW+1)'(1);
    else if (32'(active_r) > MAX_SLOTS) n_slots = (SW+1)'(MAX_SLOTS);
    else n_slots = (SW+1)'(active_r);
  end

  assign in_ready = (state_r == ST_IDLE) && !o_valid_r;
  assign in_fire  = in_valid && in_ready;
  assign widx     = idx_r[SW-1:0];

  // decision for the slot at the walk position
  always_comb begin
    hit    = 1'b0;
    hit_ph = PH_MOVE;
    if (stop_r) begin
      hit = down_r[widx]; hit_ph = PH_CANCEL;
    end else if (slot_mode_r) begin
      priority if (present_r[widx] && !down_r[widx]) begin
        hit = 1'b1; hit_ph = PH_DOWN;
      end else if (present_r[widx] && moved_r[widx]) begin
        hit = 1'b1; hit_ph = PH_MOVE;
      end else if (!present_r[widx] && down_r[widx]) begin
        hit = 1'b1; hit_ph = PH_UP;
      end else begin
        hit = 1'b0;
      end
    end else begin
      priority if (button_r && !down_r[0]) begin
        hit = 1'b1; hit_ph = PH_DOWN;
      end else if (button_r && single_moved_r) begin
        hit = 1'b1; hit_ph = PH_MOVE;
      end else if (!button_r && down_r[0]) begin
        hit = 1'b1; hit_ph = PH_UP;
      end else begin
        hit = 1'b0;
      end
    end
  end

  // last result when no later slot would hit; idx_r already points past the current slot
  always_comb begin
    is_last = 1'b1;
    for (int i = 0; i < MAX_SLOTS; i++) begin
      if ((SW+1)'(i) >= idx_r && (SW+1)'(i) < n_slots && slot_mode_r | stop_r) begin
        if (stop_r) begin
          if (down_r[i]) is_last = 1'b0;
        end else if ((present_r[i] && (!down_r[i] || moved_r[i])) ||
                     (!present_r[i] && down_r[i])) begin
          is_last = 1'b0;
        end
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire && (in_req_type ||
            (in_ev_type == EVT_SYN && in_ev_code == C_SYN_REPORT)))
          state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (idx_r >= n_slots || (!slot_mode_r && !stop_r && idx_r != '0))
          state_nxt = ST_IDLE;
        else if (hit) state_nxt = ST_NORM;
      end
      ST_NORM: begin
        if (nctl.done && axis_y_r) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!o_valid_r) state_nxt = ST_WALK;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and slot state updates
  always_comb begin
    present_nxt      = present_r;
    down_nxt         = down_r;
    moved_nxt        = moved_r;
    sel_nxt          = sel_r;
    single_moved_nxt = single_moved_r;
    button_nxt       = button_r;
    stop_nxt         = stop_r;
    idx_nxt          = idx_r;
    axis_y_nxt       = axis_y_r;
    ph_nxt           = ph_r;
    eslot_nxt        = eslot_r;
    norm_start       = 1'b0;
    load_out         = 1'b0;
    o_valid_nxt      = o_valid_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          idx_nxt  = '0;
          stop_nxt = in_req_type;
          if (!in_req_type && in_ev_type == EVT_ABS) begin
            if (in_ev_code == C_MT_SLOT) begin
              if (!in_ev_value[RAW_W-1] && in_ev_value < RAW_W'(n_slots))
                sel_nxt = in_ev_value[SW-1:0];
            end else if (in_ev_code == C_MT_TRACK) begin
              present_nxt[sel_r] = !in_ev_value[RAW_W-1];
              if (in_ev_value[RAW_W-1]) moved_nxt[sel_r] = 1'b1;
            end else if (in_ev_code == C_MT_X || in_ev_code == C_ABS_X ||
                         in_ev_code == C_MT_Y || in_ev_code == C_ABS_Y) begin
              moved_nxt[sel_r] = 1'b1;
              single_moved_nxt = 1'b1;
            end
          end else if (!in_req_type && in_ev_type == EVT_KEY &&
                       in_ev_code == C_BTN_TOUCH) begin
            button_nxt = (in_ev_value != '0);
          end
        end
      end
      ST_WALK: begin
        if (idx_r >= n_slots || (!slot_mode_r && !stop_r && idx_r != '0)) begin
          stop_nxt = 1'b0;
        end else begin
          eslot_nxt = widx;
          ph_nxt    = hit_ph;
          if (hit) begin
            norm_start = 1'b1;
            axis_y_nxt = 1'b0;
            unique case (hit_ph)
              PH_DOWN:   down_nxt[widx] = 1'b1;
              PH_UP,
              PH_CANCEL: down_nxt[widx] = 1'b0;
              default:   down_nxt[widx] = down_r[widx];
            endcase
          end
          if (!stop_r) begin
            if (slot_mode_r) moved_nxt[widx] = 1'b0;
            else single_moved_nxt = 1'b0;
          end
          idx_nxt = idx_r + (SW+1)'(1);
        end
      end
      ST_NORM: begin
        if (nctl.done && !axis_y_r) begin
          axis_y_nxt = 1'b1;
          norm_start = 1'b1;
        end
      end
      ST_OUT: begin
        if (!o_valid_r) begin
          load_out    = 1'b1;
          o_valid_nxt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign n_raw = axis_y_nxt ? cy_r[eslot_nxt] : cx_r[eslot_nxt];
  assign n_lo  = axis_y_nxt ? y_min_r : x_min_r;
  assign n_hi  = axis_y_nxt ? y_max_r : x_max_r;

  mct_norm u_norm (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (norm_start),
    .raw    (n_raw),
    .lo     (n_lo),
    .hi     (n_hi),
    .ctl    (nctl),
    .result (nres)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_mode_r    <= 1'b1;
      active_r       <= CNT_W'(16);
      x_min_r        <= '0;
      x_max_r        <= 16'sd1080;
      y_min_r        <= '0;
      y_max_r        <= 16'sd2400;
      present_r      <= '0;
      down_r         <= '0;
      moved_r        <= '0;
      sel_r          <= '0;
      single_moved_r <= 1'b0;
      button_r       <= 1'b0;
      state_r        <= ST_IDLE;
      stop_r         <= 1'b0;
      idx_r          <= '0;
      axis_y_r       <= 1'b0;
      o_valid_r      <= 1'b0;
      for (int i = 0; i < MAX_SLOTS; i++) begin
        cx_r[i] <= '0;
        cy_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_SLOT_MODE: slot_mode_r <= cfg_data[0];
          REG_ACTIVE:    active_r    <= cfg_data[CNT_W-1:0];
          REG_X_MIN:     x_min_r     <= cfg_data;
          REG_X_MAX:     x_max_r     <= cfg_data;
          REG_Y_MIN:     y_min_r     <= cfg_data;
          REG_Y_MAX:     y_max_r     <= cfg_data;
          default: ;
        endcase
      end
      if (in_fire && !in_req_type && in_ev_type == EVT_ABS) begin
        if (in_ev_code == C_MT_X || in_ev_code == C_ABS_X) cx_r[sel_r] <= in_ev_value;
        if (in_ev_code == C_MT_Y || in_ev_code == C_ABS_Y) cy_r[sel_r] <= in_ev_value;
      end
      present_r      <= present_nxt;
      down_r         <= down_nxt;
      moved_r        <= moved_nxt;
      sel_r          <= sel_nxt;
      single_moved_r <= single_moved_nxt;
      button_r       <= button_nxt;
      state_r        <= state_nxt;
      stop_r         <= stop_nxt;
      idx_r          <= idx_nxt;
      axis_y_r       <= axis_y_nxt;
      o_valid_r      <= o_valid_nxt;
    end
    ph_r    <= ph_nxt;
    eslot_r <= eslot_nxt;
    // divider results wait here so a result held at the output stays unchanged
    if (nctl.done && !axis_y_r) nx_r <= nres;
    if (nctl.done && axis_y_r)  ny_r <= nres;
    if (load_out) begin
      o_phase_r <= ph_r;
      o_id_r    <= ID_W'(eslot_r);
      o_rx_r    <= cx_r[eslot_r];
      o_ry_r    <= cy_r[eslot_r];
      o_nx_r    <= nx_r;
      o_ny_r    <= ny_r;
      o_last_r  <= is_last;
    end
  end

  assign out_valid       = o_valid_r;
  assign out_phase       = o_phase_r;
  assign out_contact_id  = o_id_r;
  assign out_raw_x       = o_rx_r;
  assign out_raw_y       = o_ry_r;
  assign out_norm_x      = o_nx_r;
  assign out_norm_y      = o_ny_r;
  assign out_last_of_run = o_last_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_IDLE |-> !in_ready) else $error("item accepted mid walk");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_phase))
    else $error("result dropped under stall");
  a_norm_only_in_norm: assert property (@(posedge clk) disable iff (!rst_n)
    nctl.done |-> state_r == ST_NORM) else $error("divider done outside normalize");
`endif

endmodule
